### rtl/sgpf_pkg.sv
package sgpf_pkg;

   localparam int unsigned MAX_N   = 65535;
   localparam int          MAP_AW  = $clog2(MAX_N + 1);
   localparam int          SIEVE_W = MAP_AW + 1;
   localparam int          SUM_W   = 16;
   localparam int          SMALL_W = 15;
   localparam int          LARGE_W = 16;

   typedef enum logic [0:0] {
      ACT_BUILD = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_P_TEST,
      ST_P_CHECK,
      ST_MARK,
      ST_QSCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load_req;
      logic fill_init;
      logic fill_write;
      logic sieve_init;
      logic p_read;
      logic mark_init;
      logic mark_write;
      logic p_next;
      logic set_ready;
      logic q_init;
      logic q_scan;
      logic res_build;
      logic res_none;
      logic res_hit;
   } cmd_type;

   typedef struct packed {
      logic fill_last;
      logic sq_over;
      logic p_prime;
      logic mark_last;
      logic sieve_ready;
      logic hit;
      logic exhausted;
   } status_type;

endpackage

### rtl/sgpf_req_if.sv
interface sgpf_req_if
   import sgpf_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             action;
   logic [SUM_W-1:0] target_sum;

   modport source (output valid, output action, output target_sum, input ready);
   modport sink (input valid, input action, input target_sum, output ready);
endinterface

### rtl/sgpf_rsp_if.sv
interface sgpf_rsp_if
   import sgpf_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               found;
   logic [SMALL_W-1:0] smaller_prime;
   logic [LARGE_W-1:0] larger_prime;
   logic               build_done;

   modport source (output valid, output found, output smaller_prime, output larger_prime,
                   output build_done, input ready);
   modport sink (input valid, input found, input smaller_prime, input larger_prime,
                 input build_done, output ready);
endinterface

### rtl/sieve_goldbach_pair_finder_top.sv
// channel    dir  fields                                            transaction
// req_chan   in   action, target_sum                                valid & ready
// rsp_chan   out  found, smaller_prime, larger_prime, build_done    valid & ready
//
// one transaction in flight; the result is held in an output register until taken
// build: fill all MAX_N+1 bitmap entries, test each candidate p up to sqrt(MAX_N), then clear
// each multiple of a prime p from p*p, one per cycle; the single-bit bitmap write port sets the pace
// query: probes i from 2 up to n/2, one bitmap pair per cycle on two read ports
// reset clears the state machine and the ready flag; a query before a build gives found 0
// a stalled result blocks the input channel until it is taken
module sieve_goldbach_pair_finder_top
   import sgpf_pkg::*;
(
   input logic          clock,
   input logic          reset,
   sgpf_req_if.sink     req_chan,
   sgpf_rsp_if.source   rsp_chan
);

   cmd_type    cmd;
   status_type stat;
   logic       req_ready;
   logic       rsp_valid;

   sgpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .rsp_ready  (rsp_chan.ready),
      .stat       (stat),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   sgpf_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_target_sum    (req_chan.target_sum),
      .stat              (stat),
      .rsp_found         (rsp_chan.found),
      .rsp_smaller_prime (rsp_chan.smaller_prime),
      .rsp_larger_prime  (rsp_chan.larger_prime),
      .rsp_build_done    (rsp_chan.build_done)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

### rtl/sgpf_ctrl.sv
module sgpf_ctrl
   import sgpf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_action,
   input  logic       rsp_ready,
   input  status_type stat,
   output logic       req_ready,
   output logic       rsp_valid,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_BUILD) begin
                  state_in = ST_FILL;
               end else if (stat.sieve_ready) begin
                  state_in = ST_QSCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_FILL: begin
            if (stat.fill_last) state_in = ST_P_TEST;
         end
         ST_P_TEST: begin
            state_in = stat.sq_over ? ST_RESP : ST_P_CHECK;
         end
         ST_P_CHECK: begin
            state_in = stat.p_prime ? ST_MARK : ST_P_TEST;
         end
         ST_MARK: begin
            if (stat.mark_last) state_in = ST_P_TEST;
         end
         ST_QSCAN: begin
            if (stat.hit || stat.exhausted) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (req_action == ACT_BUILD) begin
                  cmd.fill_init = 1'b1;
               end else if (stat.sieve_ready) begin
                  cmd.q_init = 1'b1;
               end else begin
                  cmd.res_none = 1'b1;
               end
            end
         end
         ST_FILL: begin
            cmd.fill_write = 1'b1;
            if (stat.fill_last) cmd.sieve_init = 1'b1;
         end
         ST_P_TEST: begin
            if (stat.sq_over) begin
               cmd.set_ready = 1'b1;
               cmd.res_build = 1'b1;
            end else begin
               cmd.p_read = 1'b1;
            end
         end
         ST_P_CHECK: begin
            if (stat.p_prime) begin
               cmd.mark_init = 1'b1;
            end else begin
               cmd.p_next = 1'b1;
            end
         end
         ST_MARK: begin
            cmd.mark_write = 1'b1;
            if (stat.mark_last) cmd.p_next = 1'b1;
         end
         ST_QSCAN: begin
            cmd.q_scan = 1'b1;
            if (stat.hit) begin
               cmd.res_hit = 1'b1;
            end else if (stat.exhausted) begin
               cmd.res_none = 1'b1;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/sgpf_dp.sv
module sgpf_dp
   import sgpf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [SUM_W-1:0]   req_target_sum,
   output status_type         stat,
   output logic               rsp_found,
   output logic [SMALL_W-1:0] rsp_smaller_prime,
   output logic [LARGE_W-1:0] rsp_larger_prime,
   output logic               rsp_build_done
);

   // primality bitmap
   logic map_mem [0:MAX_N];

   logic [SUM_W-1:0]   n_ff, n_in;
   logic [SIEVE_W-1:0] idx_ff, idx_in;
   logic [SIEVE_W-1:0] p_ff, p_in;
   logic [SIEVE_W-1:0] sq_ff, sq_in;
   logic [SUM_W-1:0]   qi_ff, qi_in;
   logic [SUM_W-1:0]   chk_i_ff, chk_i_in;
   logic               chk_valid_ff, chk_valid_in;
   logic               chk_oor_ff, chk_oor_in;
   logic               ready_ff, ready_in;
   logic               found_ff, found_in;
   logic [SMALL_W-1:0] small_ff, small_in;
   logic [LARGE_W-1:0] large_ff, large_in;
   logic               done_ff, done_in;
   logic               rd_a_ff, rd_b_ff;

   logic               wr_en;
   logic               wr_data;
   logic [MAP_AW-1:0]  wr_addr;
   logic [MAP_AW-1:0]  rd_a_addr;
   logic [MAP_AW-1:0]  rd_b_addr;
   logic [SUM_W-1:0]   qdiff;
   logic [SUM_W-1:0]   half;
   logic               issue_ok;
   logic [SIEVE_W-1:0] idx_step;

   assign half     = n_ff >> 1;
   assign qdiff    = n_ff - qi_ff;
   assign issue_ok = (qi_ff <= half);
   assign idx_step = idx_ff + p_ff;

   assign wr_en     = cmd.fill_write | cmd.mark_write;
   assign wr_data   = cmd.fill_write & (idx_ff > SIEVE_W'(1));
   assign wr_addr   = MAP_AW'(idx_ff);
   assign rd_a_addr = cmd.p_read ? MAP_AW'(p_ff) : MAP_AW'(qi_ff);
   assign rd_b_addr = MAP_AW'(qdiff);

   always_ff @(posedge clock) begin
      if (wr_en) map_mem[wr_addr] <= wr_data;
      rd_a_ff <= map_mem[rd_a_addr];
      rd_b_ff <= map_mem[rd_b_addr];
   end

   always_comb begin
      n_in         = n_ff;
      idx_in       = idx_ff;
      p_in         = p_ff;
      sq_in        = sq_ff;
      qi_in        = qi_ff;
      chk_i_in     = chk_i_ff;
      chk_valid_in = chk_valid_ff;
      chk_oor_in   = chk_oor_ff;
      ready_in     = ready_ff;
      found_in     = found_ff;
      small_in     = small_ff;
      large_in     = large_ff;
      done_in      = done_ff;

      if (cmd.load_req) n_in = req_target_sum;
      if (cmd.fill_init) idx_in = '0;
      if (cmd.fill_write) idx_in = idx_ff + SIEVE_W'(1);
      if (cmd.sieve_init) begin
         p_in  = SIEVE_W'(2);
         sq_in = SIEVE_W'(4);
      end
      if (cmd.mark_init) idx_in = sq_ff;
      if (cmd.mark_write) idx_in = idx_step;
      // (p+1)^2 = p^2 + 2p + 1
      if (cmd.p_next) begin
         p_in  = p_ff + SIEVE_W'(1);
         sq_in = sq_ff + (p_ff << 1) + SIEVE_W'(1);
      end
      if (cmd.set_ready) ready_in = 1'b1;

      if (cmd.q_init) begin
         qi_in        = SUM_W'(2);
         chk_valid_in = 1'b0;
      end
      if (cmd.q_scan) begin
         qi_in        = qi_ff + SUM_W'(1);
         chk_valid_in = issue_ok;
         chk_i_in     = qi_ff;
         chk_oor_in   = (qi_ff > MAX_N) || (qdiff > MAX_N);
      end

      if (cmd.res_build) begin
         found_in = 1'b0;
         small_in = '0;
         large_in = '0;
         done_in  = 1'b1;
      end
      if (cmd.res_none) begin
         found_in = 1'b0;
         small_in = '0;
         large_in = '0;
         done_in  = 1'b0;
      end
      if (cmd.res_hit) begin
         found_in = 1'b1;
         small_in = chk_i_ff[SMALL_W-1:0];
         large_in = n_ff - chk_i_ff;
         done_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff <= 1'b0;
         ready_ff     <= 1'b0;
      end else begin
         chk_valid_ff <= chk_valid_in;
         ready_ff     <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      idx_ff     <= idx_in;
      p_ff       <= p_in;
      sq_ff      <= sq_in;
      qi_ff      <= qi_in;
      chk_i_ff   <= chk_i_in;
      chk_oor_ff <= chk_oor_in;
      found_ff   <= found_in;
      small_ff   <= small_in;
      large_ff   <= large_in;
      done_ff    <= done_in;
   end

   assign stat.fill_last   = (idx_ff == SIEVE_W'(MAX_N));
   assign stat.sq_over     = (sq_ff > SIEVE_W'(MAX_N));
   assign stat.p_prime     = rd_a_ff;
   assign stat.mark_last   = (idx_step > SIEVE_W'(MAX_N));
   assign stat.sieve_ready = ready_ff;
   assign stat.hit         = chk_valid_ff & rd_a_ff & rd_b_ff & ~chk_oor_ff;
   assign stat.exhausted   = ~chk_valid_ff & ~issue_ok;

   assign rsp_found         = found_ff;
   assign rsp_smaller_prime = small_ff;
   assign rsp_larger_prime  = large_ff;
   assign rsp_build_done    = done_ff;

endmodule

### tb/sieve_goldbach_pair_finder_top_tb.sv
`timescale 1ns / 1ps

module sieve_goldbach_pair_finder_top_tb;
   import sgpf_pkg::*;

   localparam int QUIET_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 100;
   localparam int HOLD_AFTER   = 30;
   localparam int HOLD_CYCLES  = 500;
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      logic               found;
      logic [SMALL_W-1:0] smaller_prime;
      logic [LARGE_W-1:0] larger_prime;
      logic               build_done;
   } pair_result_type;

   class goldbach_scoreboard;
      bit              prime_map[0:MAX_N];
      bit              sieve_built;
      pair_result_type pending_pairs[$];
      int              failures;

      function void note_request(action_type action, logic [SUM_W-1:0] n);
         pair_result_type expected_pair;
         int              p;
         int              m;
         int              i;
         expected_pair = '{found: 1'b0, smaller_prime: '0, larger_prime: '0, build_done: 1'b0};
         if (action == ACT_BUILD) begin
            foreach (prime_map[k]) prime_map[k] = 1'b1;
            prime_map[0] = 1'b0;
            prime_map[1] = 1'b0;
            for (p = 2; p * p <= int'(MAX_N); p++) begin
               if (prime_map[p]) begin
                  for (m = p * p; m <= int'(MAX_N); m += p) prime_map[m] = 1'b0;
               end
            end
            sieve_built = 1'b1;
            expected_pair.build_done = 1'b1;
         end else if (sieve_built) begin
            for (i = 2; i <= int'(n) / 2; i++) begin
               if (prime_map[i] && prime_map[int'(n) - i]) begin
                  expected_pair.found         = 1'b1;
                  expected_pair.smaller_prime = i[SMALL_W-1:0];
                  expected_pair.larger_prime  = n - i[SUM_W-1:0];
                  break;
               end
            end
         end
         pending_pairs.insert(pending_pairs.size(), expected_pair);
      endfunction

      function void check_result(logic found, logic [SMALL_W-1:0] smaller_prime,
                                 logic [LARGE_W-1:0] larger_prime, logic build_done);
         pair_result_type want;
         if (pending_pairs.size() == 0) begin
            $error("unexpected result: found %0d smaller %0d larger %0d build_done %0d",
                   found, smaller_prime, larger_prime, build_done);
            failures++;
            return;
         end
         want = pending_pairs.pop_front();
         if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            failures++;
         end
         if (smaller_prime !== want.smaller_prime) begin
            $error("smaller_prime: expected %0d, actual %0d", want.smaller_prime, smaller_prime);
            failures++;
         end
         if (larger_prime !== want.larger_prime) begin
            $error("larger_prime: expected %0d, actual %0d", want.larger_prime, larger_prime);
            failures++;
         end
         if (build_done !== want.build_done) begin
            $error("build_done: expected %0d, actual %0d", want.build_done, build_done);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   sgpf_req_if req_chan();
   sgpf_rsp_if rsp_chan();

   sieve_goldbach_pair_finder_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   goldbach_scoreboard sb = new;

   int sender_calm;
   int results_taken;
   bit random_build_sent;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send_item(action_type action, logic [SUM_W-1:0] n);
      int r;
      int gap;
      req_chan.valid      <= 1'b1;
      req_chan.action     <= action;
      req_chan.target_sum <= n;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(action, n);
      r   = $urandom_range(0, 99);
      gap = 0;
      if (sender_calm > 0) begin
         sender_calm--;
      end else if (r < 45) begin
         gap = 0;
      end else if (r < 85) begin
         gap = $urandom_range(1, 3);
      end else if (r < 93) begin
         gap = $urandom_range(8, 40);
      end else begin
         sender_calm = $urandom_range(5, 12);
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [SUM_W-1:0] pick_sum();
      int               r;
      logic [SUM_W-1:0] n;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         n = SUM_W'($urandom_range(0, 300));
      end else if (r < 75) begin
         n    = SUM_W'($urandom_range(0, 65535));
         n[0] = 1'b0;
      end else if (r < 96) begin
         n = SUM_W'($urandom_range(0, 4095));
      end else begin
         n = SUM_W'($urandom_range(0, 65535));
      end
      return n;
   endfunction

   // result side: random stalls, calm stretches and one long hold-off
   initial begin
      int stall_left;
      int calm_left;
      int r;
      bit held_off;
      stall_left     = 0;
      calm_left      = 0;
      held_off       = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            sb.check_result(rsp_chan.found, rsp_chan.smaller_prime, rsp_chan.larger_prime,
                            rsp_chan.build_done);
            results_taken++;
         end
         if (!held_off && results_taken >= HOLD_AFTER) begin
            held_off   = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (calm_left > 0) begin
               calm_left--;
            end else if (r < 20) begin
               stall_left = $urandom_range(1, 3);
            end else if (r < 23) begin
               stall_left = $urandom_range(10, 40);
            end else if (r < 26) begin
               calm_left = $urandom_range(20, 60);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int k;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.action     <= ACT_BUILD;
      req_chan.target_sum <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // queries before any build
      send_item(ACT_QUERY, 16'd0);
      send_item(ACT_QUERY, 16'd4);
      send_item(ACT_QUERY, 16'd65535);

      send_item(ACT_BUILD, 16'd0);

      // below four, smallest pairs, odd sums with and without a pair
      send_item(ACT_QUERY, 16'd0);
      send_item(ACT_QUERY, 16'd1);
      send_item(ACT_QUERY, 16'd2);
      send_item(ACT_QUERY, 16'd3);
      send_item(ACT_QUERY, 16'd4);
      send_item(ACT_QUERY, 16'd5);
      send_item(ACT_QUERY, 16'd6);
      send_item(ACT_QUERY, 16'd7);
      send_item(ACT_QUERY, 16'd11);
      send_item(ACT_QUERY, 16'd100);
      send_item(ACT_QUERY, 16'd32768);
      send_item(ACT_QUERY, 16'd43690);
      send_item(ACT_QUERY, 16'd65534);
      send_item(ACT_QUERY, 16'd65535);

      // repeated build
      send_item(ACT_BUILD, 16'hFFFF);
      send_item(ACT_QUERY, 16'd1000);

      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (!random_build_sent && $urandom_range(0, 99) < 2) begin
            random_build_sent = 1'b1;
            send_item(ACT_BUILD, SUM_W'($urandom_range(0, 65535)));
         end else begin
            send_item(ACT_QUERY, pick_sum());
         end
      end
      req_chan.valid <= 1'b0;

      while (sb.pending_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
